>>> rtl/mux_seven_segment_text_display_assert.svh
// Assertion macros shared by the checkers of the seven-segment text display.
// Needs a signal named clock and a signal named reset in the scope of use.
`ifndef MUX_SEVEN_SEGMENT_TEXT_DISPLAY_ASSERT_SVH
`define MUX_SEVEN_SEGMENT_TEXT_DISPLAY_ASSERT_SVH

// Condition and consequence in the same cycle
`define MSSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition, then consequence in the next cycle
`define MSSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mssd_pkg.sv
// Types, constants and the ASCII font of the seven-segment text display.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mssd_pkg;

   localparam int SEG_W        = 8;
   localparam int DIGIT_LINE_W = 4;
   localparam int CHAR_W       = 8;

   localparam logic [SEG_W-1:0]        SEG_MASK   = 8'hFF;
   localparam logic [SEG_W-1:0]        POINT_BIT  = 8'h80;
   localparam logic [CHAR_W-1:0]       DOT_CODE   = 8'h2E;
   localparam logic [DIGIT_LINE_W-1:0] DIGIT_IDLE = 4'hF;

   // What one input item asks for
   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_CHAR    = 3'd1,
      ACT_ENABLE  = 3'd2,
      ACT_DISABLE = 3'd3,
      ACT_CLEAR   = 3'd4
   } action_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [CHAR_W-1:0] char_code;
      logic              first_char;
      logic              last_char;
      logic              wake_flag;
   } req_type;

   typedef struct packed {
      logic                    pins_driven;
      logic [DIGIT_LINE_W-1:0] digit_lines;
      logic [SEG_W-1:0]        segment_lines;
   } rsp_type;

   // ASCII font, segments a..g in bits 0..6; anything not listed is blank
   function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] code);
      logic [SEG_W-1:0] seg;
      seg = '0;
      case (code)
         8'h2D: seg = 8'h40;  // -
         8'h2E: seg = 8'h80;  // .
         8'h30: seg = 8'h3F;
         8'h31: seg = 8'h06;
         8'h32: seg = 8'h5B;
         8'h33: seg = 8'h4F;
         8'h34: seg = 8'h66;
         8'h35: seg = 8'h6D;
         8'h36: seg = 8'h7D;
         8'h37: seg = 8'h07;
         8'h38: seg = 8'h7F;
         8'h39: seg = 8'h6F;
         8'h41: seg = 8'h77;  // A
         8'h43: seg = 8'h39;  // C
         8'h45: seg = 8'h79;  // E
         8'h46: seg = 8'h71;  // F
         8'h47: seg = 8'h3D;  // G
         8'h48: seg = 8'h76;  // H
         8'h49: seg = 8'h06;  // I
         8'h4A: seg = 8'h0E;  // J
         8'h4C: seg = 8'h38;  // L
         8'h4F: seg = 8'h3F;  // O
         8'h50: seg = 8'h73;  // P
         8'h53: seg = 8'h6D;  // S
         8'h55: seg = 8'h3E;  // U
         8'h5F: seg = 8'h08;  // _
         8'h62: seg = 8'h7C;  // b
         8'h63: seg = 8'h58;  // c
         8'h64: seg = 8'h5E;  // d
         8'h67: seg = 8'h6F;  // g
         8'h68: seg = 8'h74;  // h
         8'h6E: seg = 8'h54;  // n
         8'h6F: seg = 8'h5C;  // o
         8'h70: seg = 8'h73;  // p
         8'h71: seg = 8'h67;  // q
         8'h72: seg = 8'h50;  // r
         8'h74: seg = 8'h78;  // t
         8'h75: seg = 8'h1C;  // u
         8'h79: seg = 8'h6E;  // y
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mux_seven_segment_text_display.sv
// Top level of the multiplexed seven-segment text display driver.
// Depends on mssd_pkg, mssd_engine and mssd_out_buf.
//
//   channel | dir | tdata (low bit up)                         | side band
//   req     | in  | char_code[7:0] first_char[8] wake_flag[9]   | tuser action, tlast last_char
//   rsp     | out | pins_driven[0] digit_lines[4:1] seg[12:5]   | none
//
// One item per cycle while rsp_tready is high; results are offered from the output register.
// The path is input register, state update logic, then the output register.
// Reset clears the text, the scan and the pins (digits high, segments low).
// A two-entry output buffer absorbs a stall; req_tready drops once both entries
// and the input register hold items.
`timescale 1ns / 1ps
`default_nettype none

module mux_seven_segment_text_display #(
   parameter int DIGIT_COUNT = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // char_code[7:0], first_char[8], wake_flag[9]
   input  wire  [2:0]  req_tuser,   // action[2:0]
   input  wire         req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // pins_driven[0], digit_lines[4:1], segment_lines[12:5]
);
   import mssd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    buf_ready;
   logic    fire;
   rsp_type result;
   rsp_type rsp_item;

   assign fire       = in_valid_ff && buf_ready;
   assign req_tready = !in_valid_ff || buf_ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in           = 1'b1;
         in_item_in.action     = req_tuser;
         in_item_in.char_code  = req_tdata[7:0];
         in_item_in.first_char = req_tdata[8];
         in_item_in.wake_flag  = req_tdata[9];
         in_item_in.last_char  = req_tlast;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   mssd_engine #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .item_fire (fire),
      .item      (in_item_ff),
      .result    (result)
   );

   mssd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (in_valid_ff),
      .push_ready (buf_ready),
      .push_data  (result),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.segment_lines, rsp_item.digit_lines,
                       rsp_item.pins_driven};

endmodule

`default_nettype wire

>>> rtl/mssd_engine.sv
// Display state (segment buffer, scan, text cursor, pin hold) and its update
// for one item per cycle while item_fire is high. Depends on mssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssd_engine #(
   parameter int DIGIT_COUNT = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               item_fire,
   input  mssd_pkg::req_type item,
   output mssd_pkg::rsp_type result
);
   import mssd_pkg::*;

   localparam int SCAN_W = $clog2(DIGIT_COUNT);
   localparam int WP_W   = $clog2(DIGIT_COUNT + 1);

   logic [SEG_W-1:0]        buf_ff [DIGIT_COUNT];
   logic [SEG_W-1:0]        buf_in [DIGIT_COUNT];
   logic [SCAN_W-1:0]       scan_ff, scan_in;
   logic                    on_ff, on_in;
   logic [WP_W-1:0]         wp_ff, wp_in;
   logic                    full_ff, full_in;
   logic [DIGIT_LINE_W-1:0] digit_ff, digit_in;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic                    driven_ff, driven_in;

   // Update for the current item
   always_comb begin
      action_type       act;
      logic             clear_all;
      logic             is_char;
      logic [WP_W-1:0]  eff_wp;
      logic             eff_full;
      logic             do_point;
      logic             do_glyph;
      logic             room;
      logic             wake_pt;
      logic [SEG_W-1:0] pattern;
      logic [2:0]       idx3;

      act       = action_type'(item.action);
      is_char   = (act == ACT_CHAR);
      clear_all = (is_char && item.first_char) || (act == ACT_CLEAR) ||
                  (act == ACT_DISABLE && on_ff);

      // A first character restarts the text
      eff_wp   = (is_char && item.first_char) ? '0 : wp_ff;
      eff_full = (is_char && item.first_char) ? 1'b0 : full_ff;
      room     = (eff_wp < WP_W'(DIGIT_COUNT));
      do_point = is_char && !eff_full && (eff_wp != '0) && (item.char_code == DOT_CODE);
      do_glyph = is_char && !eff_full && !do_point && room;
      wake_pt  = is_char && item.last_char && item.wake_flag;
      pattern  = glyph(item.char_code);

      for (int k = 0; k < DIGIT_COUNT; k++) begin
         buf_in[k] = clear_all ? '0 : buf_ff[k];
         if (do_glyph && eff_wp == WP_W'(k)) begin
            buf_in[k] = pattern;
         end
         if (do_point && eff_wp == WP_W'(k + 1)) begin
            buf_in[k] = buf_in[k] | POINT_BIT;
         end
         if (wake_pt && k == DIGIT_COUNT - 1) begin
            buf_in[k] = buf_in[k] | POINT_BIT;
         end
      end

      wp_in   = is_char ? (do_glyph ? eff_wp + 1'b1 : eff_wp) : wp_ff;
      full_in = is_char ? (eff_full || (!do_point && !room)) : full_ff;

      scan_in   = scan_ff;
      on_in     = on_ff;
      digit_in  = digit_ff;
      seg_in    = seg_ff;
      driven_in = driven_ff;
      idx3      = 3'(scan_ff);

      case (act)
         ACT_TICK: begin
            if (on_ff) begin
               for (int b = 0; b < DIGIT_LINE_W; b++) begin
                  digit_in[b] = (idx3 != 3'(b));
               end
               seg_in  = SEG_MASK & ~buf_ff[scan_ff];
               scan_in = (scan_ff == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + 1'b1;
            end
         end
         ACT_ENABLE: begin
            if (!on_ff) begin
               digit_in  = DIGIT_IDLE;
               seg_in    = SEG_MASK;
               driven_in = 1'b1;
               on_in     = 1'b1;
            end
         end
         ACT_DISABLE: begin
            if (on_ff) begin
               digit_in  = DIGIT_IDLE;
               seg_in    = '0;
               driven_in = 1'b0;
               on_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.pins_driven   = driven_in;
   assign result.digit_lines   = digit_in;
   assign result.segment_lines = seg_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            buf_ff[k] <= '0;
         end
         scan_ff   <= '0;
         on_ff     <= 1'b0;
         wp_ff     <= '0;
         full_ff   <= 1'b0;
         digit_ff  <= DIGIT_IDLE;
         seg_ff    <= '0;
         driven_ff <= 1'b0;
      end else if (item_fire) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            buf_ff[k] <= buf_in[k];
         end
         scan_ff   <= scan_in;
         on_ff     <= on_in;
         wp_ff     <= wp_in;
         full_ff   <= full_in;
         digit_ff  <= digit_in;
         seg_ff    <= seg_in;
         driven_ff <= driven_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mssd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on mssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssd_out_buf (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  mssd_pkg::rsp_type push_data,
   output logic              pop_valid,
   input  wire               pop_ready,
   output mssd_pkg::rsp_type pop_data
);
   import mssd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;

   // Fill and drain
   always_comb begin
      logic push;
      logic pop;
      push          = push_valid && !skid_valid_ff;
      pop           = main_valid_ff && pop_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_ready = !skid_valid_ff;
   assign pop_valid  = main_valid_ff;
   assign pop_data   = main_data_ff;

endmodule

`default_nettype wire

>>> rtl/mssd_checker.sv
// Port-level checks on the result channel of the seven-segment text display.
// Depends on mux_seven_segment_text_display_assert.svh; bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "mux_seven_segment_text_display_assert.svh"

module mssd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata
);

   // Result fields as they sit in tdata
   wire       pins_driven   = rsp_tdata[0];
   wire [3:0] digit_lines   = rsp_tdata[4:1];
   wire [7:0] segment_lines = rsp_tdata[12:5];
   wire       rsp_stall     = rsp_tvalid && !rsp_tready;
   wire       lines_idle    = (digit_lines == 4'hF) && (segment_lines == 8'h00);

   // A stalled item holds
   `MSSD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled item changed")

   // Released pins show no digit and no segment
   `MSSD_ASSERT_NOW(a_idle_pins, rsp_tvalid && !pins_driven, lines_idle, "released pins not idle")

   // Scan selects at most one digit
   `MSSD_ASSERT_NOW(a_one_digit, rsp_tvalid, $countones(~digit_lines) <= 1, "two digits selected")

   // Padding bits stay zero
   `MSSD_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[15:13] == 3'b000, "rsp padding not zero")

endmodule

bind mux_seven_segment_text_display mssd_checker u_mssd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> test/mux_seven_segment_text_display_tb.sv
// Self-checking testbench for mux_seven_segment_text_display: streams tick, text,
// enable, disable and clear items, predicts the pin state after each, checks results.
// Depends on mssd_pkg and the display driver RTL.
`timescale 1ns / 1ps

module mux_seven_segment_text_display_tb;
   import mssd_pkg::*;

   localparam int NUM_DIGITS = 4;
   // action codes the block leaves unused
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int TOTAL_ITEMS      = 1750;
   localparam int QUIET_TAIL       = 250;
   localparam int LONG_HOLD_AT     = 500;
   localparam int LONG_HOLD_CYCLES = 100;

   typedef struct {
      req_type cmd;
      bit      wait_drain;   // hold this item until every result is back
   } queued_cmd_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // char_code[7:0], first_char[8], wake_flag[9]
   logic [2:0]  req_tuser  = '0;   // action[2:0]
   logic        req_tlast  = 1'b0; // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // pins_driven[0], digit_lines[4:1], segment_lines[12:5]

   queued_cmd_type cmd_backlog[$];
   rsp_type        pin_states_due[$];
   int             failures   = 0;
   bit             quiet      = 1'b0;
   bit             drain_next = 1'b0;

   // display state as the block should hold it
   logic [SEG_W-1:0] text_segs [NUM_DIGITS];
   int unsigned      scan_pos  = 0;
   bit               lit       = 1'b0;
   int unsigned      text_pos  = 0;
   bit               text_done = 1'b0;
   rsp_type          pins_now;

   // driver and monitor bookkeeping
   req_type        current_cmd;
   queued_cmd_type next_cmd;
   int             send_gap      = 0;
   int             hold_left     = 0;
   int             results_seen  = 0;
   bit             long_hold_done = 1'b0;
   rsp_type        want;
   rsp_type        got;

   mux_seven_segment_text_display #(
      .DIGIT_COUNT(NUM_DIGITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ASCII font, segments a..g in bits 0..6; codes not listed are blank
   function automatic logic [SEG_W-1:0] font_pattern(input logic [CHAR_W-1:0] code);
      case (code)
         "-": return 8'h40;
         ".": return 8'h80;
         "0", "O": return 8'h3F;
         "1", "I": return 8'h06;
         "2": return 8'h5B;
         "3": return 8'h4F;
         "4": return 8'h66;
         "5", "S": return 8'h6D;
         "6": return 8'h7D;
         "7": return 8'h07;
         "8": return 8'h7F;
         "9", "g": return 8'h6F;
         "A": return 8'h77;
         "C": return 8'h39;
         "E": return 8'h79;
         "F": return 8'h71;
         "G": return 8'h3D;
         "H": return 8'h76;
         "J": return 8'h0E;
         "L": return 8'h38;
         "P", "p": return 8'h73;
         "U": return 8'h3E;
         "_": return 8'h08;
         "b": return 8'h7C;
         "c": return 8'h58;
         "d": return 8'h5E;
         "h": return 8'h74;
         "n": return 8'h54;
         "o": return 8'h5C;
         "q": return 8'h67;
         "r": return 8'h50;
         "t": return 8'h78;
         "u": return 8'h1C;
         "y": return 8'h6E;
         default: return 8'h00;
      endcase
   endfunction

   function automatic void blank_text();
      for (int k = 0; k < NUM_DIGITS; k++) text_segs[k] = '0;
   endfunction

   // Update the display state for one accepted item and queue the pins it leaves
   function automatic void advance_display(input req_type c);
      int unsigned idx;
      case (c.action)
         ACT_TICK: begin
            if (lit) begin
               idx = scan_pos % NUM_DIGITS;
               pins_now.digit_lines = DIGIT_IDLE;
               if (idx < DIGIT_LINE_W) pins_now.digit_lines[idx] = 1'b0;
               pins_now.segment_lines = ~text_segs[idx];
               scan_pos = (idx + 1) % NUM_DIGITS;
            end
         end
         ACT_CHAR: begin
            if (c.first_char) begin
               blank_text();
               text_pos  = 0;
               text_done = 1'b0;
            end
            if (!text_done) begin
               // a point after a glyph lands on that glyph's digit
               if (text_pos > 0 && c.char_code == DOT_CODE) begin
                  if (text_pos <= NUM_DIGITS) text_segs[text_pos-1] |= POINT_BIT;
               end else if (text_pos < NUM_DIGITS) begin
                  text_segs[text_pos] = font_pattern(c.char_code);
                  text_pos++;
               end else begin
                  text_done = 1'b1;
               end
            end
            if (c.last_char && c.wake_flag) text_segs[NUM_DIGITS-1] |= POINT_BIT;
         end
         ACT_ENABLE: begin
            if (!lit) begin
               pins_now.pins_driven   = 1'b1;
               pins_now.digit_lines   = DIGIT_IDLE;
               pins_now.segment_lines = SEG_MASK;
               lit = 1'b1;
            end
         end
         ACT_DISABLE: begin
            if (lit) begin
               pins_now.pins_driven   = 1'b0;
               pins_now.digit_lines   = DIGIT_IDLE;
               pins_now.segment_lines = '0;
               blank_text();
               lit = 1'b0;
            end
         end
         ACT_CLEAR: blank_text();
         default: ;
      endcase
      pin_states_due.push_back(pins_now);
   endfunction

   task automatic queue_cmd(input logic [2:0] act, input logic [CHAR_W-1:0] code,
                            input bit first, input bit last, input bit wake);
      queued_cmd_type q;
      q.cmd.action     = act;
      q.cmd.char_code  = code;
      q.cmd.first_char = first;
      q.cmd.last_char  = last;
      q.cmd.wake_flag  = wake;
      q.wait_drain     = drain_next;
      drain_next       = 1'b0;
      cmd_backlog.push_back(q);
   endtask

   // mostly printable glyphs, plenty of points, some of the full code range
   function automatic logic [CHAR_W-1:0] pick_text_char();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 5) return DOT_CODE;
      if (r < 7) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h2D, 8'h7A));
   endfunction

   // Sender: offers items from the backlog, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) advance_display(current_cmd);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_backlog.size() == 0 ||
                         (cmd_backlog[0].wait_drain && pin_states_due.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               next_cmd    = cmd_backlog.pop_front();
               current_cmd = next_cmd.cmd;
               req_tdata  <= {6'b0, current_cmd.wake_flag, current_cmd.first_char,
                              current_cmd.char_code};
               req_tuser  <= current_cmd.action;
               req_tlast  <= current_cmd.last_char;
               req_tvalid <= 1'b1;
               if (cmd_backlog.size() < QUIET_TAIL) quiet <= 1'b1;
               else if ($urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 16);
            end
         end
      end
   end

   // Receiver: checks each result item, stalls in bursts and once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pins_driven   = rsp_tdata[0];
            got.digit_lines   = rsp_tdata[4:1];
            got.segment_lines = rsp_tdata[12:5];
            if (pin_states_due.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = pin_states_due.pop_front();
               if (got.pins_driven !== want.pins_driven) begin
                  $display("%0t: pins_driven expected %b actual %b",
                           $time, want.pins_driven, got.pins_driven);
                  failures++;
               end
               if (got.digit_lines !== want.digit_lines) begin
                  $display("%0t: digit_lines expected %b actual %b",
                           $time, want.digit_lines, got.digit_lines);
                  failures++;
               end
               if (got.segment_lines !== want.segment_lines) begin
                  $display("%0t: segment_lines expected %h actual %h",
                           $time, want.segment_lines, got.segment_lines);
                  failures++;
               end
            end
            results_seen++;
         end
         if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            hold_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int unsigned pick;
      int unsigned len;
      bit          wake;

      blank_text();
      pins_now.pins_driven   = 1'b0;
      pins_now.digit_lines   = DIGIT_IDLE;
      pins_now.segment_lines = '0;

      // idle corner cases, unused actions, repeated enable
      queue_cmd(ACT_TICK, 8'h00, 0, 0, 0);
      queue_cmd(ACT_DISABLE, 8'h00, 0, 0, 0);
      queue_cmd(ACT_SPARE_LO, 8'hFF, 1, 1, 1);
      queue_cmd(ACT_SPARE_HI, 8'h00, 0, 0, 0);
      queue_cmd(ACT_ENABLE, 8'h00, 0, 0, 0);
      queue_cmd(ACT_ENABLE, 8'h00, 0, 0, 0);
      // point first, trailing point, code past 'z', overflow, wake on the last char
      queue_cmd(ACT_CHAR, DOT_CODE, 1, 0, 0);
      queue_cmd(ACT_CHAR, "8", 0, 0, 0);
      queue_cmd(ACT_CHAR, DOT_CODE, 0, 0, 1);
      queue_cmd(ACT_CHAR, "b", 0, 0, 0);
      queue_cmd(ACT_CHAR, 8'h7B, 0, 0, 0);
      queue_cmd(ACT_CHAR, DOT_CODE, 0, 0, 0);
      queue_cmd(ACT_CHAR, "H", 0, 0, 0);
      queue_cmd(ACT_CHAR, "3", 0, 0, 0);
      queue_cmd(ACT_CHAR, 8'hFF, 0, 1, 1);
      repeat (4) queue_cmd(ACT_TICK, 8'h00, 0, 0, 0);
      // code zero as a blank glyph, then a character with no first mark
      queue_cmd(ACT_CHAR, 8'h00, 1, 0, 1);
      queue_cmd(ACT_CHAR, "2", 0, 1, 0);
      queue_cmd(ACT_TICK, 8'h00, 0, 0, 0);
      queue_cmd(ACT_CLEAR, 8'h00, 0, 0, 0);
      queue_cmd(ACT_DISABLE, 8'h00, 0, 0, 0);
      queue_cmd(ACT_ENABLE, 8'h00, 0, 0, 0);

      // random part: mostly well-formed texts followed by scan ticks
      drain_next = 1'b1;
      while (cmd_backlog.size() < TOTAL_ITEMS) begin
         if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len  = $urandom_range(1, 7);
            wake = 1'($urandom_range(0, 1));
            for (int k = 0; k < len; k++)
               queue_cmd(ACT_CHAR, pick_text_char(),
                         (k == 0) && ($urandom_range(0, 9) != 0), k == len - 1, wake);
            repeat ($urandom_range(1, 8)) queue_cmd(ACT_TICK, 8'h00, 0, 0, 0);
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 12)) queue_cmd(ACT_TICK, 8'h00, 0, 0, 0);
         end else if (pick < 78) begin
            queue_cmd(ACT_ENABLE, 8'h00, 0, 0, 0);
         end else if (pick < 82) begin
            queue_cmd(ACT_DISABLE, 8'h00, 0, 0, 0);
            if ($urandom_range(0, 4) != 0) queue_cmd(ACT_ENABLE, 8'h00, 0, 0, 0);
         end else if (pick < 87) begin
            queue_cmd(ACT_CLEAR, 8'h00, 0, 0, 0);
         end else begin
            // noise: every field random, unused actions included
            queue_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (pin_states_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("** mux_seven_segment_text_display: PASSED **");
      end else begin
         $display("** mux_seven_segment_text_display: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("** mux_seven_segment_text_display: FAILED **");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/mssd_pkg.sv
rtl/mssd_engine.sv
rtl/mssd_out_buf.sv
rtl/mux_seven_segment_text_display.sv
rtl/mssd_checker.sv
test/mux_seven_segment_text_display_tb.sv
